### sv/cpa_pkg.sv
// ============================================================================
// cpa_pkg: shared types and codes of the contiguous page allocator
// Beat payloads, page and status codes, and the controller/datapath link.
// ============================================================================
package cpa_pkg;

    // Request opcodes
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_MARK    = 2'd2;
    localparam logic [1:0] OP_CHECK   = 2'd3;

    // Response status codes
    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_NO_SPACE     = 2'd1;
    localparam logic [1:0] ST_FRAGMENTED   = 2'd2;
    localparam logic [1:0] ST_OUT_OF_RANGE = 2'd3;

    // Page map entry codes
    localparam logic [1:0] PG_FREE     = 2'd0;
    localparam logic [1:0] PG_RESERVED = 2'd1;
    localparam logic [1:0] PG_WRITTEN  = 2'd2;

    // Configuration register reset value
    localparam logic [8:0] PAGES_IN_USE_RESET = 9'd256;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] start_page;
        logic [8:0] page_count;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] granted_page;
        logic       page_written;
    } rsp_t;

    // What the decode step asks for next
    typedef enum logic [1:0] {
        ACT_DONE,
        ACT_SCAN,
        ACT_FILL,
        ACT_PROBE
    } act_t;

    typedef struct packed {
        logic load;
        logic decode;
        logic scan;
        logic fill;
        logic probe;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        act_t act;
        logic scan_found;
        logic scan_exhausted;
        logic fill_last;
    } sts_t;

endpackage

### sv/cpa_ctrl.sv
// ============================================================================
// cpa_ctrl: request sequencer of the contiguous page allocator
// After the reset sweep, steps each request through decode, scan, fill or probe, then hands off.
// ============================================================================
module cpa_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output cpa_pkg::cmd_t cmd,
    input  cpa_pkg::sts_t sts
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_FILL,
        S_PROBE,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   req_ready_reg;
    logic   req_ready_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   out_free;

    assign out_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.fill = 1'b1;
                if (sts.fill_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                case (sts.act)
                    cpa_pkg::ACT_SCAN:  state_next = S_SCAN;
                    cpa_pkg::ACT_FILL:  state_next = S_FILL;
                    cpa_pkg::ACT_PROBE: state_next = S_PROBE;
                    default:            state_next = S_DONE;
                endcase
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_found)
                begin
                    state_next = S_FILL;
                end
                else if (sts.scan_exhausted)
                begin
                    state_next = S_DONE;
                end
            end
            S_FILL:
            begin
                cmd.fill = 1'b1;
                if (sts.fill_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_PROBE:
            begin
                cmd.probe  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready_next = (state_next == S_IDLE);
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            req_ready_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            req_ready_reg <= req_ready_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = req_ready_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

### sv/cpa_datapath.sv
// ============================================================================
// cpa_datapath: page map and scan/fill engine of the page allocator
// Holds the page map memory, the first-fit run tracker and the result.
// ============================================================================
module cpa_datapath
#(
    parameter int MAX_PAGES = 256
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cpa_pkg::cmd_t cmd,
    output cpa_pkg::sts_t sts,
    input  cpa_pkg::req_t req,
    input  logic          cfg_we,
    input  logic [8:0]    cfg_wdata,
    output cpa_pkg::rsp_t rsp
);

    localparam int AW = $clog2(MAX_PAGES);
    localparam int PW = (AW > 9) ? AW + 1 : 10;
    localparam logic [PW-1:0] PAGES_W = PW'(MAX_PAGES);

    logic [1:0]     mem [MAX_PAGES];
    logic [1:0]     mem_q_reg;

    cpa_pkg::req_t  req_reg;
    cpa_pkg::rsp_t  res_reg;
    cpa_pkg::rsp_t  rsp_reg;
    logic [8:0]     piu_reg;
    logic [PW-1:0]  n_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  chk_ptr_reg;
    logic           pend_reg;
    logic [PW-1:0]  run_reg;
    logic [PW-1:0]  free_reg;
    logic [PW-1:0]  run_start_reg;
    logic [PW-1:0]  fill_ptr_reg;
    logic [PW-1:0]  fill_end_reg;
    logic [1:0]     fill_code_reg;

    logic [PW-1:0]  start_w;
    logic [PW-1:0]  count_w;
    logic [PW-1:0]  sum_w;
    logic [PW-1:0]  piu_w;
    logic [PW-1:0]  n_eff;
    cpa_pkg::act_t  act;
    cpa_pkg::rsp_t  dec_res;
    logic           mark_we;
    logic           is_free;
    logic           issue;
    logic [PW-1:0]  run_new;
    logic [PW-1:0]  free_new;
    logic [PW-1:0]  run_start_new;
    logic           found;
    logic           exhausted;
    logic           fill_last;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [1:0]     mem_wdata;
    logic [AW-1:0]  mem_raddr;

    assign start_w = PW'(req_reg.start_page);
    assign count_w = PW'(req_reg.page_count);
    assign sum_w   = start_w + count_w;
    assign piu_w   = PW'(piu_reg);
    assign n_eff   = (piu_w > PAGES_W) ? PAGES_W : piu_w;

    // Decode: bounds checks and choice of the next step
    always_comb
    begin
        act     = cpa_pkg::ACT_DONE;
        dec_res = '{status: cpa_pkg::ST_OK, granted_page: 8'd0, page_written: 1'b0};
        mark_we = 1'b0;
        case (req_reg.op)
            cpa_pkg::OP_ALLOC:
            begin
                if (count_w > n_reg)
                begin
                    dec_res.status = cpa_pkg::ST_NO_SPACE;
                end
                else if (count_w != '0)
                begin
                    act = cpa_pkg::ACT_SCAN;
                end
            end
            cpa_pkg::OP_RELEASE:
            begin
                if (sum_w > n_reg)
                begin
                    dec_res.status = cpa_pkg::ST_OUT_OF_RANGE;
                end
                else if (count_w != '0)
                begin
                    act = cpa_pkg::ACT_FILL;
                end
            end
            cpa_pkg::OP_MARK:
            begin
                if (start_w >= n_reg)
                begin
                    dec_res.status = cpa_pkg::ST_OUT_OF_RANGE;
                end
                else
                begin
                    mark_we = 1'b1;
                end
            end
            default:
            begin
                if (start_w >= n_reg)
                begin
                    dec_res.status = cpa_pkg::ST_OUT_OF_RANGE;
                end
                else
                begin
                    act = cpa_pkg::ACT_PROBE;
                end
            end
        endcase
    end

    // First-fit run tracking on the entry read in the previous cycle
    assign is_free       = (mem_q_reg == cpa_pkg::PG_FREE);
    assign issue         = (rd_ptr_reg < n_reg);
    assign run_new       = is_free ? run_reg + 1'b1 : '0;
    assign free_new      = is_free ? free_reg + 1'b1 : free_reg;
    assign run_start_new = is_free ? run_start_reg : chk_ptr_reg + 1'b1;
    assign found         = pend_reg && (run_new == count_w);
    assign exhausted     = !pend_reg && !issue;
    assign fill_last     = ((fill_ptr_reg + 1'b1) == fill_end_reg);

    assign sts.act            = act;
    assign sts.scan_found     = found;
    assign sts.scan_exhausted = exhausted;
    assign sts.fill_last      = fill_last;

    // Memory port selection
    assign mem_we    = cmd.fill || (cmd.decode && mark_we);
    assign mem_waddr = cmd.fill ? fill_ptr_reg[AW-1:0] : start_w[AW-1:0];
    assign mem_wdata = cmd.fill ? fill_code_reg : cpa_pkg::PG_WRITTEN;
    assign mem_raddr = cmd.scan ? rd_ptr_reg[AW-1:0] : start_w[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            piu_reg       <= cpa_pkg::PAGES_IN_USE_RESET;
            fill_ptr_reg  <= '0;
            fill_end_reg  <= PAGES_W;
            fill_code_reg <= cpa_pkg::PG_FREE;
            pend_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                piu_reg <= cfg_wdata;
            end
            if (cmd.decode && (act == cpa_pkg::ACT_FILL))
            begin
                fill_ptr_reg  <= start_w;
                fill_end_reg  <= sum_w;
                fill_code_reg <= cpa_pkg::PG_FREE;
            end
            else if (cmd.scan && found)
            begin
                fill_ptr_reg  <= run_start_new;
                fill_end_reg  <= run_start_new + count_w;
                fill_code_reg <= cpa_pkg::PG_RESERVED;
            end
            else if (cmd.fill)
            begin
                fill_ptr_reg <= fill_ptr_reg + 1'b1;
            end
            pend_reg <= cmd.scan && issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
            n_reg   <= n_eff;
        end
        if (cmd.decode)
        begin
            res_reg       <= dec_res;
            rd_ptr_reg    <= '0;
            run_reg       <= '0;
            free_reg      <= '0;
            run_start_reg <= '0;
        end
        if (cmd.scan)
        begin
            if (issue)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            chk_ptr_reg <= rd_ptr_reg;
            if (pend_reg)
            begin
                run_reg       <= run_new;
                free_reg      <= free_new;
                run_start_reg <= run_start_new;
            end
            if (found)
            begin
                res_reg.status       <= cpa_pkg::ST_OK;
                res_reg.granted_page <= run_start_new[7:0];
            end
            else if (exhausted)
            begin
                res_reg.status <= (free_reg < count_w) ? cpa_pkg::ST_NO_SPACE
                                                       : cpa_pkg::ST_FRAGMENTED;
            end
        end
        if (cmd.probe)
        begin
            res_reg.page_written <= (mem_q_reg == cpa_pkg::PG_WRITTEN);
        end
        if (cmd.out_load)
        begin
            rsp_reg <= res_reg;
        end
    end

    assign rsp = rsp_reg;

endmodule

### sv/contiguous_page_allocator_unit.sv
// Accept to response valid: mark, zero-length and rejected requests are settled at decode; check adds
//   a probe, release a range fill, allocate a scan that stops at a fitting run and fills it, or runs out.
// Throughput: one request at a time, one map entry per cycle; the next request is taken the
//   cycle after the previous response is loaded, which waits while an older one is pending.
// Reset: all MAX_PAGES entries of the page map are swept to free with req_ready low; config writes
//   are taken during the sweep.
// ============================================================================
// contiguous_page_allocator_unit: first-fit contiguous page allocator
// Allocates, releases, marks and checks pages of a swap page map.
// ============================================================================
module contiguous_page_allocator_unit
#(
    parameter int MAX_PAGES = 256
)
(
    input  logic          clk,
    input  logic          rst_n,
    // request channel
    input  logic          req_valid,
    output logic          req_ready,
    input  cpa_pkg::req_t req,
    // response channel
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output cpa_pkg::rsp_t rsp,
    // pages_in_use register
    input  logic          cfg_we,
    input  logic [8:0]    cfg_wdata
);

    cpa_pkg::cmd_t cmd;
    cpa_pkg::sts_t sts;

    // Controller: sequences each request beat through decode, map scan,
    // range fill or single-page probe, then parks the response beat in the
    // output register as soon as the previous one has been taken.
    cpa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Datapath: page map memory with a registered read, the first-fit run
    // tracker fed one entry per cycle, the range fill pointer, and the
    // result and output registers.
    cpa_datapath #(
        .MAX_PAGES (MAX_PAGES)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rsp       (rsp)
    );

    // An accepted request beat is decoded in the following cycle.
    a_accept_decode: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> cmd.decode
    ) else $error("accepted request was not decoded next cycle");

    // Never overwrite a response beat that is still waiting.
    a_no_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!rsp_valid || rsp_ready)
    ) else $error("response register loaded while a beat was pending");

    // Only a successful response carries a granted page or a written flag.
    a_fail_fields_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != cpa_pkg::ST_OK))
            |-> ((rsp.granted_page == 8'd0) && !rsp.page_written)
    ) else $error("failed response carries page data");

    // No new request is taken while a request is still in flight.
    a_one_in_flight: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd.scan || cmd.fill || cmd.probe || cmd.decode) |-> !req_ready
    ) else $error("request accepted while another is in progress");

endmodule

### tb/sv/tb_contiguous_page_allocator_unit.sv
// ============================================================================
// tb_contiguous_page_allocator_unit: self-checking bench of the page allocator
// Walks a short scripted sequence with hand-written answers at the extremes,
// then runs phases of random allocate/release/mark/check traffic under several
// pages_in_use settings. Unpinned responses are checked against a local page map.
// ============================================================================
module tb_contiguous_page_allocator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAP_DEPTH      = 256;
    localparam int IDLE_PCT       = 18;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int NUM_PHASES     = 8;

    // One line of the scripted sequence: either a register write or a request,
    // optionally with its answer typed in (pinned).
    typedef struct packed {
        logic       is_cfg;
        logic [8:0] cfg_val;
        logic [1:0] op;
        logic [7:0] start_page;
        logic [8:0] page_count;
        logic       pinned;
        logic [1:0] status;
        logic [7:0] granted;
        logic       written;
    } script_row_t;

    typedef struct {
        int base_page;
        int span;
    } page_run_t;

    localparam script_row_t SCRIPT [30] = '{
        '{1'b1, 9'd256, cpa_pkg::OP_ALLOC, 8'd0, 9'd0, 1'b0, cpa_pkg::ST_OK, 8'd0, 1'b0},
        // fresh map: everything free, nothing written
        '{1'b0, 9'd0, cpa_pkg::OP_CHECK, 8'd0, 9'd0, 1'b1, cpa_pkg::ST_OK, 8'd0, 1'b0},
        '{1'b0, 9'd0, cpa_pkg::OP_ALLOC, 8'd0, 9'd0, 1'b1, cpa_pkg::ST_OK, 8'd0, 1'b0},
        '{1'b0, 9'd0, cpa_pkg::OP_ALLOC, 8'd0, 9'd511, 1'b1, cpa_pkg::ST_NO_SPACE, 8'd0, 1'b0},
        '{1'b0, 9'd0, cpa_pkg::OP_ALLOC, 8'd255, 9'd256, 1'b1, cpa_pkg::ST_OK, 8'd0, 1'b0},
        '{1'b0, 9'd0, cpa_pkg::OP_ALLOC, 8'd0, 9'd1, 1'b1, cpa_pkg::ST_NO_SPACE, 8'd0, 1'b0},
        '{1'b0, 9'd0, cpa_pkg::OP_MARK, 8'd255, 9'd511, 1'b1, cpa_pkg::ST_OK, 8'd0, 1'b0},
        '{1'b0, 9'd0, cpa_pkg::OP_CHECK, 8'd255, 9'd0, 1'b1, cpa_pkg::ST_OK, 8'd0, 1'b1},
        '{1'b0, 9'd0, cpa_pkg::OP_RELEASE, 8'd0, 9'd256, 1'b1, cpa_pkg::ST_OK, 8'd0, 1'b0},
        '{1'b0, 9'd0, cpa_pkg::OP_RELEASE, 8'd255, 9'd2, 1'b1,
          cpa_pkg::ST_OUT_OF_RANGE, 8'd0, 1'b0},
        '{1'b0, 9'd0, cpa_pkg::OP_RELEASE, 8'd0, 9'd511, 1'b1,
          cpa_pkg::ST_OUT_OF_RANGE, 8'd0, 1'b0},
        '{1'b0, 9'd0, cpa_pkg::OP_ALLOC, 8'd0, 9'd3, 1'b1, cpa_pkg::ST_OK, 8'd0, 1'b0},
        '{1'b0, 9'd0, cpa_pkg::OP_ALLOC, 8'd0, 9'd5, 1'b1, cpa_pkg::ST_OK, 8'd3, 1'b0},
        // punch a one-page hole and write into a reserved run
        '{1'b0, 9'd0, cpa_pkg::OP_RELEASE, 8'd1, 9'd1, 1'b0, cpa_pkg::ST_OK, 8'd0, 1'b0},
        '{1'b0, 9'd0, cpa_pkg::OP_MARK, 8'd4, 9'd0, 1'b0, cpa_pkg::ST_OK, 8'd0, 1'b0},
        '{1'b0, 9'd0, cpa_pkg::OP_ALLOC, 8'd0, 9'd2, 1'b0, cpa_pkg::ST_OK, 8'd0, 1'b0},
        // too few free pages, then enough pages but no run long enough
        '{1'b0, 9'd0, cpa_pkg::OP_ALLOC, 8'd0, 9'd250, 1'b0, cpa_pkg::ST_OK, 8'd0, 1'b0},
        '{1'b0, 9'd0, cpa_pkg::OP_ALLOC, 8'd0, 9'd247, 1'b0, cpa_pkg::ST_OK, 8'd0, 1'b0},
        '{1'b0, 9'd0, cpa_pkg::OP_CHECK, 8'd3, 9'd0, 1'b0, cpa_pkg::ST_OK, 8'd0, 1'b0},
        '{1'b0, 9'd0, cpa_pkg::OP_RELEASE, 8'd0, 9'd0, 1'b1, cpa_pkg::ST_OK, 8'd0, 1'b0},
        // no pages managed at all
        '{1'b1, 9'd0, cpa_pkg::OP_ALLOC, 8'd0, 9'd0, 1'b0, cpa_pkg::ST_OK, 8'd0, 1'b0},
        '{1'b0, 9'd0, cpa_pkg::OP_ALLOC, 8'd0, 9'd0, 1'b1, cpa_pkg::ST_OK, 8'd0, 1'b0},
        '{1'b0, 9'd0, cpa_pkg::OP_ALLOC, 8'd0, 9'd1, 1'b1, cpa_pkg::ST_NO_SPACE, 8'd0, 1'b0},
        '{1'b0, 9'd0, cpa_pkg::OP_MARK, 8'd0, 9'd0, 1'b1,
          cpa_pkg::ST_OUT_OF_RANGE, 8'd0, 1'b0},
        '{1'b0, 9'd0, cpa_pkg::OP_RELEASE, 8'd0, 9'd0, 1'b1, cpa_pkg::ST_OK, 8'd0, 1'b0},
        // a single page, then a setting past the map size
        '{1'b1, 9'd1, cpa_pkg::OP_ALLOC, 8'd0, 9'd0, 1'b0, cpa_pkg::ST_OK, 8'd0, 1'b0},
        '{1'b0, 9'd0, cpa_pkg::OP_CHECK, 8'd1, 9'd0, 1'b1,
          cpa_pkg::ST_OUT_OF_RANGE, 8'd0, 1'b0},
        '{1'b0, 9'd0, cpa_pkg::OP_RELEASE, 8'd0, 9'd1, 1'b0, cpa_pkg::ST_OK, 8'd0, 1'b0},
        '{1'b1, 9'd511, cpa_pkg::OP_ALLOC, 8'd0, 9'd0, 1'b0, cpa_pkg::ST_OK, 8'd0, 1'b0},
        '{1'b0, 9'd0, cpa_pkg::OP_CHECK, 8'd255, 9'd0, 1'b0, cpa_pkg::ST_OK, 8'd0, 1'b0}
    };

    localparam logic [8:0] PHASE_CFG [NUM_PHASES] =
        '{9'd256, 9'd40, 9'd1, 9'd511, 9'd0, 9'd128, 9'd17, 9'd256};
    localparam int PHASE_ITEMS [NUM_PHASES] = '{120, 120, 30, 120, 20, 120, 100, 120};

    // ------------------------------------------------------------------------
    // DUT connections; every input starts at a known value
    // ------------------------------------------------------------------------
    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_ready;
    cpa_pkg::req_t req       = '0;
    logic          rsp_valid;
    logic          rsp_ready = 1'b0;
    cpa_pkg::rsp_t rsp;
    logic          cfg_we    = 1'b0;
    logic [8:0]    cfg_wdata = '0;

    // Side band of the current request beat: a typed-in answer, if any
    logic          beat_pinned = 1'b0;
    cpa_pkg::rsp_t beat_rsp    = '0;

    // Turns off idling on both channels for a long stretch
    logic          steady = 1'b0;

    // Local copy of the allocator state
    logic [1:0]    page_state [MAP_DEPTH] = '{default: cpa_pkg::PG_FREE};
    logic [8:0]    pages_cfg = cpa_pkg::PAGES_IN_USE_RESET;

    cpa_pkg::rsp_t expected_rsp [$];
    page_run_t     live_runs [$];

    int            errors = 0;
    int            op_count [4] = '{default: 0};
    int            status_count [4] = '{default: 0};

    contiguous_page_allocator_unit #(
        .MAX_PAGES (MAP_DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Page map prediction: apply one request to the local map, return the answer
    // ------------------------------------------------------------------------
    function automatic cpa_pkg::rsp_t predict_page_op(cpa_pkg::req_t r);
        cpa_pkg::rsp_t res;
        int   n;
        int   want;
        int   run;
        int   free_seen;
        int   run_start;
        int   i;
        res  = '0;
        n    = (int'(pages_cfg) > MAP_DEPTH) ? MAP_DEPTH : int'(pages_cfg);
        want = int'(r.page_count);
        res.status = cpa_pkg::ST_OK;
        case (r.op)
            cpa_pkg::OP_ALLOC:
            begin
                if (want > n)
                    res.status = cpa_pkg::ST_NO_SPACE;
                else
                begin
                    // First fit: restart the run after every page that is not free
                    run       = 0;
                    free_seen = 0;
                    run_start = 0;
                    for (i = 0; run < want && i < n; i++)
                    begin
                        if (page_state[i] == cpa_pkg::PG_FREE)
                        begin
                            run++;
                            free_seen++;
                        end
                        else
                        begin
                            run       = 0;
                            run_start = i + 1;
                        end
                    end
                    if (run >= want)
                    begin
                        for (i = 0; i < want; i++)
                            page_state[run_start + i] = cpa_pkg::PG_RESERVED;
                        res.granted_page = run_start[7:0];
                    end
                    else if (free_seen < want)
                        res.status = cpa_pkg::ST_NO_SPACE;
                    else
                        res.status = cpa_pkg::ST_FRAGMENTED;
                end
            end
            cpa_pkg::OP_RELEASE:
            begin
                if (int'(r.start_page) + want > n)
                    res.status = cpa_pkg::ST_OUT_OF_RANGE;
                else
                    for (i = 0; i < want; i++)
                        page_state[int'(r.start_page) + i] = cpa_pkg::PG_FREE;
            end
            cpa_pkg::OP_MARK:
            begin
                if (int'(r.start_page) >= n)
                    res.status = cpa_pkg::ST_OUT_OF_RANGE;
                else
                    page_state[r.start_page] = cpa_pkg::PG_WRITTEN;
            end
            default:
            begin
                if (int'(r.start_page) >= n)
                    res.status = cpa_pkg::ST_OUT_OF_RANGE;
                else
                    res.page_written = (page_state[r.start_page] == cpa_pkg::PG_WRITTEN);
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: check response beats, then predict accepted request beats.
    // A response can never belong to a request taken at the same edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cpa_pkg::rsp_t want;
        cpa_pkg::rsp_t pred;
        if (rsp_valid && rsp_ready)
        begin
            if (expected_rsp.size() == 0)
            begin
                $error("response beat with no request outstanding: %p", rsp);
                errors++;
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, rsp.status);
                    errors++;
                end
                if (rsp.granted_page !== want.granted_page)
                begin
                    $error("granted_page: expected %0d, actual %0d",
                           want.granted_page, rsp.granted_page);
                    errors++;
                end
                if (rsp.page_written !== want.page_written)
                begin
                    $error("page_written: expected %0d, actual %0d",
                           want.page_written, rsp.page_written);
                    errors++;
                end
                status_count[want.status]++;
            end
        end
        if (req_valid && req_ready)
        begin
            pred = predict_page_op(req);
            // Remember granted runs so the stimulus can hand them back later
            if (req.op == cpa_pkg::OP_ALLOC && pred.status == cpa_pkg::ST_OK
                && req.page_count != 0)
                live_runs.push_back(page_run_t'{int'(pred.granted_page),
                                                int'(req.page_count)});
            expected_rsp.push_back(beat_pinned ? beat_rsp : pred);
            op_count[req.op]++;
        end
        if (cfg_we)
            pages_cfg = cfg_wdata;
    end

    // Receiver: stall at random except during the steady stretch
    always @(negedge clk)
    begin
        rsp_ready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog: end the run when no beat moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers; every task is entered and left at a falling edge
    // ------------------------------------------------------------------------

    // Drop request valid and hold until every outstanding response has come back
    task automatic drain_responses();
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0) @(negedge clk);
    endtask

    // Write pages_in_use with the block idle
    task automatic write_pages_in_use(input logic [8:0] value);
        drain_responses();
        repeat (3) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Present one request beat and hold it until accepted. Valid is left high
    // on return, so back-to-back beats never drop it in between.
    task automatic send_beat(input cpa_pkg::req_t r, input logic pinned,
                             input cpa_pkg::rsp_t answer);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid   <= 1'b1;
        req         <= r;
        beat_pinned <= pinned;
        beat_rsp    <= answer;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Random request, weighted toward allocate and the return of granted runs.
    // Ignored fields carry noise.
    function automatic cpa_pkg::req_t next_random_req(int n);
        cpa_pkg::req_t r;
        int   pick;
        int   k;
        r.op         = cpa_pkg::OP_ALLOC;
        r.start_page = 8'($urandom_range(255));
        r.page_count = 9'($urandom_range(511));
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            k = $urandom_range(99);
            if (k < 75)
                r.page_count = 9'($urandom_range(1, 8));
            else if (k < 93)
                r.page_count = 9'($urandom_range(9, 48));
            else if (k < 97)
                r.page_count = 9'($urandom_range(0, 256));
            else
                r.page_count = 9'($urandom_range(257, 511));
        end
        else if (pick < 65 && live_runs.size() != 0)
        begin
            k = $urandom_range(live_runs.size() - 1);
            r.op         = cpa_pkg::OP_RELEASE;
            r.start_page = 8'(live_runs[k].base_page);
            r.page_count = 9'(live_runs[k].span);
            live_runs.delete(k);
        end
        else if (pick < 72)
        begin
            r.op = cpa_pkg::OP_RELEASE;
            k = $urandom_range(99);
            if (k < 5)
            begin
                // wipe the whole managed map
                r.start_page = '0;
                r.page_count = 9'(n);
            end
            else
            begin
                if (n > 0 && k < 85)
                    r.start_page = 8'($urandom_range(n - 1));
                r.page_count = (k < 95) ? 9'($urandom_range(0, 12)) : 9'($urandom_range(511));
            end
        end
        else
        begin
            r.op = (pick < 86) ? cpa_pkg::OP_MARK : cpa_pkg::OP_CHECK;
            if (n > 0 && $urandom_range(9) != 0)
                r.start_page = 8'($urandom_range(n - 1));
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        cpa_pkg::req_t r;
        cpa_pkg::rsp_t answer;
        int   n;
        int   ph;
        int   i;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Scripted part; the block may still be sweeping its map, so the
        // first beat simply waits for ready.
        foreach (SCRIPT[s])
        begin
            if (SCRIPT[s].is_cfg)
                write_pages_in_use(SCRIPT[s].cfg_val);
            else
            begin
                r.op                = SCRIPT[s].op;
                r.start_page        = SCRIPT[s].start_page;
                r.page_count        = SCRIPT[s].page_count;
                answer.status       = SCRIPT[s].status;
                answer.granted_page = SCRIPT[s].granted;
                answer.page_written = SCRIPT[s].written;
                send_beat(r, SCRIPT[s].pinned, answer);
            end
        end

        // Random phases, one register setting each
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_pages_in_use(PHASE_CFG[ph]);
            n = (int'(PHASE_CFG[ph]) > MAP_DEPTH) ? MAP_DEPTH : int'(PHASE_CFG[ph]);
            steady = (ph == 3);
            for (i = 0; i < PHASE_ITEMS[ph]; i++)
            begin
                // hold the sender once until the response side runs dry
                if (ph == 1 && i == 60)
                    drain_responses();
                send_beat(next_random_req(n), 1'b0, '0);
            end
        end
        steady    = 1'b0;
        req_valid <= 1'b0;

        drain_responses();
        repeat (8) @(negedge clk);

        $display("covered %0d allocate, %0d release, %0d mark, %0d check requests",
                 op_count[cpa_pkg::OP_ALLOC], op_count[cpa_pkg::OP_RELEASE],
                 op_count[cpa_pkg::OP_MARK], op_count[cpa_pkg::OP_CHECK]);
        $display("answers seen: %0d ok, %0d no space, %0d fragmented, %0d out of range",
                 status_count[cpa_pkg::ST_OK], status_count[cpa_pkg::ST_NO_SPACE],
                 status_count[cpa_pkg::ST_FRAGMENTED], status_count[cpa_pkg::ST_OUT_OF_RANGE]);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### contiguous_page_allocator_unit.f
sv/cpa_pkg.sv
sv/cpa_ctrl.sv
sv/cpa_datapath.sv
sv/contiguous_page_allocator_unit.sv
tb/sv/tb_contiguous_page_allocator_unit.sv
